[rtl/perceptron_trainer_core_macros.svh]
// ---------------------------------------------------------------------------
// Perceptron trainer assertion macros
// Concurrent assertion wrappers used by the trainer core. Define ASSERT_OFF
// to compile them out.
// ---------------------------------------------------------------------------
`ifndef PERCEPTRON_TRAINER_CORE_MACROS_SVH
`define PERCEPTRON_TRAINER_CORE_MACROS_SVH

`ifndef ASSERT_OFF
// Checked on every rising edge outside reset.
`define PTC_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("perceptron trainer assertion failed");
// Checked on every rising edge, reset included.
`define PTC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("perceptron trainer assertion failed");
`else
`define PTC_ASSERT(label, clk, rst, prop)
`define PTC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

[rtl/ptc_pkg.sv]
// ---------------------------------------------------------------------------
// Perceptron trainer package
// Widths, limits, register indexes and word types shared by the trainer.
// ---------------------------------------------------------------------------
package ptc_pkg;

  localparam int NUM_WEIGHTS = 5;
  localparam int FEATURE_W   = 16;
  localparam int WEIGHT_W    = 40;
  localparam int RATE_W      = 16;
  localparam int COUNT_W     = 16;
  localparam int RUN_W       = 16;
  localparam int UPD_W       = 20;
  // eta (unsigned, zero extended) times a signed feature.
  localparam int STEP_W      = RATE_W + 1 + FEATURE_W;
  localparam int PROD_W      = WEIGHT_W + FEATURE_W;
  // Five products plus headroom for the sum.
  localparam int DOT_W       = PROD_W + 4;
  localparam int SUM_W       = WEIGHT_W + 2;

  localparam logic signed [FEATURE_W-1:0] BIAS_ONE = 16'sd4096;
  localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd4096;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 16'd256;
  localparam logic [UPD_W-1:0]   UPD_MAX     = {UPD_W{1'b1}};
  localparam logic [RUN_W-1:0]   RUN_MAX     = {RUN_W{1'b1}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MAX = {1'b0, {(WEIGHT_W-1){1'b1}}};
  localparam logic signed [WEIGHT_W-1:0] WEIGHT_MIN = {1'b1, {(WEIGHT_W-1){1'b0}}};

  // Configuration register indexes.
  typedef enum logic [0:0] {
    CFG_LEARNING_RATE = 1'b0,
    CFG_SAMPLE_COUNT  = 1'b1
  } cfg_index_t;

  typedef logic signed [FEATURE_W-1:0] feature_t;
  typedef logic signed [STEP_W-1:0]    step_t;
  typedef logic signed [WEIGHT_W-1:0]  weight_t;

  // One training sample.
  typedef struct packed {
    logic                        mode;
    logic signed [FEATURE_W-1:0] feature_1;
    logic signed [FEATURE_W-1:0] feature_2;
    logic signed [FEATURE_W-1:0] feature_3;
    logic signed [FEATURE_W-1:0] feature_4;
    logic                        label;
  } sample_t;

  // One training result.
  typedef struct packed {
    logic                       mistake;
    logic                       converged;
    logic [UPD_W-1:0]           update_total;
    logic signed [WEIGHT_W-1:0] bias_weight;
    logic signed [WEIGHT_W-1:0] weight_1;
    logic signed [WEIGHT_W-1:0] weight_2;
    logic signed [WEIGHT_W-1:0] weight_3;
    logic signed [WEIGHT_W-1:0] weight_4;
  } result_t;

endpackage

[rtl/perceptron_trainer_core.sv]
// Pipeline: an accepted sample passes the input register, then the result register.
// Throughput: one sample per cycle while not stalled; the weight registers close
// a loop through the dot product, the sign test and the saturating update.
// Reset: synchronous, active high; clears weights, counters, converged flag and
// valid flags, and returns learning_rate to 1.0 and sample_count to 256.
// ---------------------------------------------------------------------------
// Perceptron trainer core
// Trains five Q16.24 weights on a stream of labelled Q4.12 samples with the
// perceptron rule and reports the state after every sample.
// ---------------------------------------------------------------------------
`include "perceptron_trainer_core_macros.svh"

module perceptron_trainer_core (
  input  logic                           clk,
  input  logic                           rst,
  // Sample channel.
  input  logic                           sample_valid,
  output logic                           sample_stall,
  input  ptc_pkg::sample_t               sample,
  // Result channel.
  output logic                           result_valid,
  input  logic                           result_stall,
  output ptc_pkg::result_t               result,
  // Configuration write channel.
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  ptc_pkg::cfg_index_t            cfg_index,
  input  logic [ptc_pkg::RATE_W-1:0]     cfg_data
);

  // Configuration registers.
  logic [ptc_pkg::RATE_W-1:0]  learning_rate;
  logic [ptc_pkg::COUNT_W-1:0] sample_count;

  // Training state.
  logic [ptc_pkg::NUM_WEIGHTS-1:0][ptc_pkg::WEIGHT_W-1:0] weights;
  logic [ptc_pkg::NUM_WEIGHTS-1:0][ptc_pkg::WEIGHT_W-1:0] weights_next;
  logic [ptc_pkg::RUN_W-1:0] correct_run;
  logic [ptc_pkg::RUN_W-1:0] correct_run_next;
  logic [ptc_pkg::UPD_W-1:0] updates_done;
  logic [ptc_pkg::UPD_W-1:0] updates_done_next;
  logic                      done_flag;
  logic                      done_flag_next;

  // Input register stage.
  logic               s1_valid;
  logic               s1_mode;
  logic               s1_label;
  ptc_pkg::feature_t  s1_x    [ptc_pkg::NUM_WEIGHTS];
  ptc_pkg::step_t     s1_step [ptc_pkg::NUM_WEIGHTS];
  ptc_pkg::feature_t  x_in    [ptc_pkg::NUM_WEIGHTS];

  // Update stage working signals.
  ptc_pkg::weight_t                  w_eff [ptc_pkg::NUM_WEIGHTS];
  logic signed [ptc_pkg::PROD_W-1:0] prod  [ptc_pkg::NUM_WEIGHTS];
  logic signed [ptc_pkg::SUM_W-1:0]  wsum  [ptc_pkg::NUM_WEIGHTS];
  logic signed [ptc_pkg::DOT_W-1:0]  dot;
  logic                              dot_pos;
  logic                              done_eff;
  logic [ptc_pkg::RUN_W-1:0]         run_eff;
  logic [ptc_pkg::UPD_W-1:0]         upd_eff;
  logic                              mistake_c;
  logic                              advance;
  ptc_pkg::result_t                  result_next;

  // The result register frees up when it is empty or being taken.
  assign advance      = s1_valid && (!result_valid || !result_stall);
  assign sample_stall = s1_valid && !advance;
  assign cfg_ready    = 1'b1;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      learning_rate <= ptc_pkg::RATE_RESET;
      sample_count  <= ptc_pkg::COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ptc_pkg::CFG_LEARNING_RATE: learning_rate <= cfg_data;
        ptc_pkg::CFG_SAMPLE_COUNT:  sample_count  <= cfg_data;
      endcase
    end
  end

  // Feature vector of the incoming sample; element zero is the bias input.
  always_comb begin
    x_in[0] = ptc_pkg::BIAS_ONE;
    x_in[1] = sample.feature_1;
    x_in[2] = sample.feature_2;
    x_in[3] = sample.feature_3;
    x_in[4] = sample.feature_4;
  end

  // Input register: the sample and its eta-scaled update terms.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sample_valid && !sample_stall) begin
      s1_mode  <= sample.mode;
      s1_label <= sample.label;
      for (int i = 0; i < ptc_pkg::NUM_WEIGHTS; i++) begin
        s1_x[i]    <= x_in[i];
        s1_step[i] <= $signed({1'b0, learning_rate}) * x_in[i];
      end
    end
  end

  // Dot product against the current (or freshly cleared) weights.
  always_comb begin
    dot = '0;
    for (int i = 0; i < ptc_pkg::NUM_WEIGHTS; i++) begin
      w_eff[i] = s1_mode ? '0 : $signed(weights[i]);
      prod[i]  = w_eff[i] * s1_x[i];
      dot      = dot + ptc_pkg::DOT_W'(prod[i]);
    end
    dot_pos = !dot[ptc_pkg::DOT_W-1] && (dot != '0);
  end

  // Classification, saturating weight update and counters.
  always_comb begin
    done_eff  = s1_mode ? 1'b0 : done_flag;
    run_eff   = s1_mode ? '0 : correct_run;
    upd_eff   = s1_mode ? '0 : updates_done;
    mistake_c = !done_eff && (s1_label ? !dot_pos : dot_pos);

    for (int i = 0; i < ptc_pkg::NUM_WEIGHTS; i++) begin
      if (s1_label) begin
        wsum[i] = ptc_pkg::SUM_W'(w_eff[i]) + ptc_pkg::SUM_W'(s1_step[i]);
      end else begin
        wsum[i] = ptc_pkg::SUM_W'(w_eff[i]) - ptc_pkg::SUM_W'(s1_step[i]);
      end
      if (!mistake_c) begin
        weights_next[i] = w_eff[i];
      end else if (wsum[i][ptc_pkg::SUM_W-1:ptc_pkg::WEIGHT_W-1] == '0 ||
                   wsum[i][ptc_pkg::SUM_W-1:ptc_pkg::WEIGHT_W-1] == '1) begin
        weights_next[i] = wsum[i][ptc_pkg::WEIGHT_W-1:0];
      end else if (wsum[i][ptc_pkg::SUM_W-1]) begin
        weights_next[i] = ptc_pkg::WEIGHT_MIN;
      end else begin
        weights_next[i] = ptc_pkg::WEIGHT_MAX;
      end
    end

    updates_done_next = upd_eff;
    if (mistake_c && upd_eff != ptc_pkg::UPD_MAX) begin
      updates_done_next = upd_eff + 1'b1;
    end

    priority if (done_eff) begin
      correct_run_next = run_eff;
    end else if (mistake_c) begin
      correct_run_next = '0;
    end else if (run_eff != ptc_pkg::RUN_MAX) begin
      correct_run_next = run_eff + 1'b1;
    end else begin
      correct_run_next = run_eff;
    end

    done_flag_next = done_eff || (correct_run_next >= sample_count);

    result_next.mistake      = mistake_c;
    result_next.converged    = done_flag_next;
    result_next.update_total = updates_done_next;
    result_next.bias_weight  = weights_next[0];
    result_next.weight_1     = weights_next[1];
    result_next.weight_2     = weights_next[2];
    result_next.weight_3     = weights_next[3];
    result_next.weight_4     = weights_next[4];
  end

  // Training state commits as the sample moves into the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      weights      <= '0;
      correct_run  <= '0;
      updates_done <= '0;
      done_flag    <= 1'b0;
    end else if (advance) begin
      weights      <= weights_next;
      correct_run  <= correct_run_next;
      updates_done <= updates_done_next;
      done_flag    <= done_flag_next;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  // Checks on the trainer's own control.
  `PTC_ASSERT_ALWAYS(a_reset_empties_output, clk, rst |=> !result_valid)
  `PTC_ASSERT(a_idle_stage_never_stalls, clk, rst, !s1_valid |-> !sample_stall)
  `PTC_ASSERT(a_mistake_clears_run, clk, rst, advance && mistake_c |=> correct_run == '0)
  `PTC_ASSERT(a_converged_holds_weights, clk, rst, advance && done_eff |=> $stable(weights))

endmodule
